// ----- src/prmmd_pkg.sv -----
// ----------------------------------------------------------------------------
// prmmd_pkg
// Shared widths, types and the square root digit step for the point to
// rectangle least / greatest distance core.
// ----------------------------------------------------------------------------
package prmmd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 25;

  // |a - b| of two coordinates fits COORD_BITS unsigned bits
  localparam int DIFF_W   = COORD_BITS;
  localparam int SQR_W    = 2 * DIFF_W;
  localparam int D2_W     = SQR_W + 1;
  localparam int RAD_W    = D2_W + 2 * FRAC_BITS;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int RAD_EVEN = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;

  // root digits resolved per square root pipeline stage
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

  // lane 0: least distance, lane 1: greatest distance
  localparam int NLANE = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIFF_W-1:0]            diff_t;
  typedef logic [SQR_W-1:0]             sqr_t;
  typedef logic [D2_W-1:0]              d2_t;
  typedef logic [RAD_EVEN-1:0]          rad_t;
  typedef logic [ROOT_W-1:0]            root_t;
  typedef logic [REM_W-1:0]             rem_t;
  typedef logic [OUT_W-1:0]             dist_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
    rad_t  rad;
  } sqrt_st_t;

  // One restoring digit step: bring down the next bit pair, try (4*root + 1).
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t         r;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    rem_sh = {s.rem, s.rad[RAD_EVEN-1 -: 2]};
    trial  = {2'b00, s.root, 2'b01};
    diff   = rem_sh - trial;
    r.rad  = {s.rad[RAD_EVEN-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = diff[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- src/prmmd_in_if.sv -----
// ----------------------------------------------------------------------------
// prmmd_in_if
// Query channel: one point and two opposite rectangle corners per transfer.
// ----------------------------------------------------------------------------
interface prmmd_in_if;
  logic              valid;
  logic              ready;
  prmmd_pkg::coord_t point_x;
  prmmd_pkg::coord_t point_y;
  prmmd_pkg::coord_t rect_x1;
  prmmd_pkg::coord_t rect_y1;
  prmmd_pkg::coord_t rect_x2;
  prmmd_pkg::coord_t rect_y2;

  modport source (
    output valid, point_x, point_y, rect_x1, rect_y1, rect_x2, rect_y2,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, rect_x1, rect_y1, rect_x2, rect_y2,
    output ready
  );
endinterface

// ----- src/prmmd_out_if.sv -----
// ----------------------------------------------------------------------------
// prmmd_out_if
// Result channel: least and greatest distance, unsigned fixed point.
// ----------------------------------------------------------------------------
interface prmmd_out_if;
  logic             valid;
  logic             ready;
  prmmd_pkg::dist_t min_dist;
  prmmd_pkg::dist_t max_dist;

  modport source (
    output valid, min_dist, max_dist,
    input  ready
  );
  modport sink (
    input  valid, min_dist, max_dist,
    output ready
  );
endinterface

// ----- src/prmmd_sqrt.sv -----
// ----------------------------------------------------------------------------
// prmmd_sqrt
// Pipelined integer square root, two lanes in lock step. Each stage resolves up to
// SQ_STEPS root digits (the last one fewer if ROOT_W is odd); the last stage is the output register.
// ----------------------------------------------------------------------------
module prmmd_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prmmd_pkg::d2_t  d2_i   [prmmd_pkg::NLANE],
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output prmmd_pkg::root_t root_o [prmmd_pkg::NLANE]
);

  logic                     v_q  [prmmd_pkg::SQ_STAGES];
  prmmd_pkg::sqrt_st_t      st_q [prmmd_pkg::SQ_STAGES][prmmd_pkg::NLANE];
  logic [prmmd_pkg::SQ_STAGES:0] en;

  assign en[prmmd_pkg::SQ_STAGES] = out_ready_i;
  assign in_ready_o               = en[0];

  for (genvar s = 0; s < prmmd_pkg::SQ_STAGES; s++) begin : g_stage
    logic                v_in;
    prmmd_pkg::sqrt_st_t st_in  [prmmd_pkg::NLANE];
    prmmd_pkg::sqrt_st_t st_nxt [prmmd_pkg::NLANE];

    // a stage moves when empty or when the one after it moves
    assign en[s] = !v_q[s] || en[s+1];

    if (s == 0) begin : g_first
      assign v_in = in_valid_i;
      for (genvar l = 0; l < prmmd_pkg::NLANE; l++) begin : g_lane
        assign st_in[l].rem  = '0;
        assign st_in[l].root = '0;
        assign st_in[l].rad  = prmmd_pkg::rad_t'(d2_i[l]) << (2 * prmmd_pkg::FRAC_BITS);
      end
    end else begin : g_next
      assign v_in  = v_q[s-1];
      assign st_in = st_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < prmmd_pkg::NLANE; l++) begin
        st_nxt[l] = st_in[l];
        for (int j = 0; j < prmmd_pkg::SQ_STEPS; j++) begin
          if (s * prmmd_pkg::SQ_STEPS + j < prmmd_pkg::ROOT_W) begin
            st_nxt[l] = prmmd_pkg::sqrt_step(st_nxt[l]);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && v_in) begin
        st_q[s] <= st_nxt;
      end
    end
  end

  assign out_valid_o = v_q[prmmd_pkg::SQ_STAGES-1];

  for (genvar l = 0; l < prmmd_pkg::NLANE; l++) begin : g_out
    assign root_o[l] = st_q[prmmd_pkg::SQ_STAGES-1][l].root;
  end

endmodule

// ----- src/point_rect_min_max_distance_core.sv -----
// ----------------------------------------------------------------------------
// point_rect_min_max_distance_core
// Least distance from a point to an axis-aligned rectangle and distance to
// its farthest corner, both as floor(sqrt(d2) * 2^FRAC_BITS).
//
//   port    dir   fields                                        transfer
//   in_i    sink  point_x/y, rect_x1/y1, rect_x2/y2 (s16)        valid & ready
//   out_o   src   min_dist, max_dist (u25, 8 fraction bits)     valid & ready
//
// One query per cycle sustained while out_o is ready; the 25-digit square
// root pipeline resolves up to two digits per stage.
// Reset clears only the valid bits; no start-up pass.
// Each stage holds its transfer while the next is full and stalled; empty
// stages still fill, so queries are taken while a result waits on out_o.
// ----------------------------------------------------------------------------
module point_rect_min_max_distance_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  prmmd_in_if.sink    in_i,
  prmmd_out_if.source out_o
);

  function automatic prmmd_pkg::diff_t abs_diff(prmmd_pkg::coord_t a,
                                                prmmd_pkg::coord_t b);
    logic signed [prmmd_pkg::COORD_BITS:0] d;
    logic signed [prmmd_pkg::COORD_BITS:0] m;
    d = {a[prmmd_pkg::COORD_BITS-1], a} - {b[prmmd_pkg::COORD_BITS-1], b};
    m = d[prmmd_pkg::COORD_BITS] ? -d : d;
    return m[prmmd_pkg::DIFF_W-1:0];
  endfunction

  // stage 1: axis gaps and strict span flags
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               en1, en2, en3, en4;
  prmmd_pkg::diff_t   ax1_q, ax2_q, ay1_q, ay2_q;
  logic               inx_q, iny_q;
  logic               inx_d, iny_d;

  // stage 2: near / far gap per axis
  prmmd_pkg::diff_t   nx_q, ny_q, fx_q, fy_q;
  prmmd_pkg::diff_t   nx_d, ny_d, fx_d, fy_d;

  // stage 3: squares
  prmmd_pkg::sqr_t    snx_q, sny_q, sfx_q, sfy_q;

  // stage 4: squared distances
  prmmd_pkg::d2_t     d2_q [prmmd_pkg::NLANE];

  logic               sq_ready;
  prmmd_pkg::root_t   root [prmmd_pkg::NLANE];

  assign en4 = !v4_q || sq_ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  assign inx_d = (in_i.rect_x1 < in_i.point_x && in_i.point_x < in_i.rect_x2) ||
                 (in_i.rect_x2 < in_i.point_x && in_i.point_x < in_i.rect_x1);
  assign iny_d = (in_i.rect_y1 < in_i.point_y && in_i.point_y < in_i.rect_y2) ||
                 (in_i.rect_y2 < in_i.point_y && in_i.point_y < in_i.rect_y1);

  // nearest gap is zero on an axis where the point sits strictly in the span
  always_comb begin
    nx_d = (ax1_q < ax2_q) ? ax1_q : ax2_q;
    fx_d = (ax1_q < ax2_q) ? ax2_q : ax1_q;
    ny_d = (ay1_q < ay2_q) ? ay1_q : ay2_q;
    fy_d = (ay1_q < ay2_q) ? ay2_q : ay1_q;
    if (inx_q) begin
      nx_d = '0;
    end
    if (iny_q) begin
      ny_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      ax1_q <= abs_diff(in_i.point_x, in_i.rect_x1);
      ax2_q <= abs_diff(in_i.point_x, in_i.rect_x2);
      ay1_q <= abs_diff(in_i.point_y, in_i.rect_y1);
      ay2_q <= abs_diff(in_i.point_y, in_i.rect_y2);
      inx_q <= inx_d;
      iny_q <= iny_d;
    end
    if (en2 && v1_q) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
    if (en3 && v2_q) begin
      snx_q <= prmmd_pkg::sqr_t'(nx_q) * prmmd_pkg::sqr_t'(nx_q);
      sny_q <= prmmd_pkg::sqr_t'(ny_q) * prmmd_pkg::sqr_t'(ny_q);
      sfx_q <= prmmd_pkg::sqr_t'(fx_q) * prmmd_pkg::sqr_t'(fx_q);
      sfy_q <= prmmd_pkg::sqr_t'(fy_q) * prmmd_pkg::sqr_t'(fy_q);
    end
    if (en4 && v3_q) begin
      d2_q[0] <= prmmd_pkg::d2_t'(snx_q) + prmmd_pkg::d2_t'(sny_q);
      d2_q[1] <= prmmd_pkg::d2_t'(sfx_q) + prmmd_pkg::d2_t'(sfy_q);
    end
  end

  prmmd_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_ready_o  (sq_ready),
    .d2_i        (d2_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .root_o      (root)
  );

  assign out_o.min_dist = prmmd_pkg::dist_t'(root[0]);
  assign out_o.max_dist = prmmd_pkg::dist_t'(root[1]);

endmodule

// ----- test/prmmd_dist_checker.sv -----
// ----------------------------------------------------------------------------
// prmmd_dist_checker
// Watches the query and result channels of the point to rectangle distance
// core, computes the least and greatest distance of every query taken and
// compares each result transfer, in order, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module prmmd_dist_checker
  import prmmd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  prmmd_in_if  in_mon,
  prmmd_out_if out_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    dist_t min_dist;
    dist_t max_dist;
  } dist_pair_t;

  dist_pair_t expected_q[$];
  int         fail_cnt    = 0;
  int         outstanding = 0;

  assign errors_o  = fail_cnt;
  assign pending_o = outstanding;

  // floor(sqrt(d2) * 2^FRAC_BITS), built one root bit at a time
  function automatic dist_t floor_root(longint unsigned d2);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned trial;
    radicand = d2 << (2 * FRAC_BITS);
    root     = 0;
    for (int b = OUT_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return dist_t'(root);
  endfunction

  function automatic dist_pair_t predict_distances(coord_t px, coord_t py, coord_t x1,
                                                   coord_t y1, coord_t x2, coord_t y2);
    longint          gx1, gx2, gy1, gy2;
    longint unsigned qx1, qx2, qy1, qy2;
    longint unsigned corner[4];
    longint unsigned nearest, farthest, least;
    bit              span_x, span_y;
    dist_pair_t      r;
    gx1 = longint'(px) - longint'(x1);
    gx2 = longint'(px) - longint'(x2);
    gy1 = longint'(py) - longint'(y1);
    gy2 = longint'(py) - longint'(y2);
    // sign drops out of the square
    qx1 = longint'(gx1 * gx1);
    qx2 = longint'(gx2 * gx2);
    qy1 = longint'(gy1 * gy1);
    qy2 = longint'(gy2 * gy2);
    corner[0] = qx1 + qy1;
    corner[1] = qx1 + qy2;
    corner[2] = qx2 + qy1;
    corner[3] = qx2 + qy2;
    nearest  = corner[0];
    farthest = corner[0];
    foreach (corner[k]) begin
      if (corner[k] < nearest)  nearest  = corner[k];
      if (corner[k] > farthest) farthest = corner[k];
    end
    // strict span only: a point on an edge falls through to the gap or corner rule
    span_x = (x1 < px && px < x2) || (x2 < px && px < x1);
    span_y = (y1 < py && py < y2) || (y2 < py && py < y1);
    if (span_x && span_y) begin
      least = 0;
    end else if (span_x) begin
      least = (qy1 < qy2) ? qy1 : qy2;
    end else if (span_y) begin
      least = (qx1 < qx2) ? qx1 : qx2;
    end else begin
      least = nearest;
    end
    r.min_dist = floor_root(least);
    r.max_dist = floor_root(farthest);
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    dist_pair_t want;
    if (rst_ni) begin
      // results first, so a result in the cycle of a query cannot hide behind it
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_cnt++;
          $error("result with no query outstanding: min_dist %0d, max_dist %0d",
                 out_mon.min_dist, out_mon.max_dist);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.min_dist !== want.min_dist) begin
            fail_cnt++;
            $error("min_dist: expected %0d, actual %0d", want.min_dist, out_mon.min_dist);
          end
          if (out_mon.max_dist !== want.max_dist) begin
            fail_cnt++;
            $error("max_dist: expected %0d, actual %0d", want.max_dist, out_mon.max_dist);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_distances(in_mon.point_x, in_mon.point_y,
                                               in_mon.rect_x1, in_mon.rect_y1,
                                               in_mon.rect_x2, in_mon.rect_y2));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ----- test/tb_point_rect_min_max_distance_core.sv -----
// ----------------------------------------------------------------------------
// tb_point_rect_min_max_distance_core
// Drives queries into the distance core: directed corner cases first, then
// random point / rectangle pairs (inside, on the boundary, within one span,
// extreme values, fully random), with random idling on both sides, a long
// result back-pressure stretch and a drain pause. Checking is done by
// prmmd_dist_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_rect_min_max_distance_core;
  import prmmd_pkg::*;

  localparam int     HOLD_CYCLES = 150;
  localparam int     SETTLE      = 40;
  localparam int     CYCLE_LIMIT = 200000;
  localparam coord_t C_MIN       = 16'sh8000;
  localparam coord_t C_MAX       = 16'sh7fff;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } query_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   cycle_cnt = 0;
  int   idle_pct  = 10;
  bit   hold_req  = 1'b0;

  prmmd_in_if  in_if ();
  prmmd_out_if out_if ();

  point_rect_min_max_distance_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  prmmd_dist_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (fail_cnt),
    .pending_o (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** point_rect_min_max_distance_core: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    int hold;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (hold = 1; hold < HOLD_CYCLES; hold++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= rst_ni && ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom();
    return coord_t'(r[15:0]);
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 6))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return -16'sd32767;
      3:       return 16'sd32766;
      4:       return '0;
      5:       return -16'sd1;
      default: return rand_coord();
    endcase
  endfunction

  // value strictly or loosely between two coordinates
  function automatic coord_t between(coord_t a, coord_t b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return coord_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.x1 = rand_coord();
    q.y1 = rand_coord();
    q.x2 = rand_coord();
    q.y2 = rand_coord();
    q.px = rand_coord();
    q.py = rand_coord();
    case ($urandom_range(0, 5))
      0: ;  // fully random
      1: begin  // small field: many shared coordinates and edge hits
        q.x1 = coord_t'(int'($urandom_range(0, 16)) - 8);
        q.y1 = coord_t'(int'($urandom_range(0, 16)) - 8);
        q.x2 = coord_t'(int'($urandom_range(0, 16)) - 8);
        q.y2 = coord_t'(int'($urandom_range(0, 16)) - 8);
        q.px = coord_t'(int'($urandom_range(0, 20)) - 10);
        q.py = coord_t'(int'($urandom_range(0, 20)) - 10);
      end
      2: begin  // inside or on the boundary
        q.px = between(q.x1, q.x2);
        q.py = between(q.y1, q.y2);
      end
      3: begin  // within one span only
        if ($urandom_range(0, 1)) q.px = between(q.x1, q.x2);
        else                      q.py = between(q.y1, q.y2);
      end
      4: begin  // on an edge line or a corner
        case ($urandom_range(0, 2))
          0:       q.px = q.x1;
          1:       q.px = q.x2;
          default: q.px = between(q.x1, q.x2);
        endcase
        case ($urandom_range(0, 2))
          0:       q.py = q.y1;
          1:       q.py = q.y2;
          default: q.py = between(q.y1, q.y2);
        endcase
      end
      default: begin
        q.px = edge_coord();
        q.py = edge_coord();
        q.x1 = edge_coord();
        q.y1 = edge_coord();
        q.x2 = edge_coord();
        q.y2 = edge_coord();
      end
    endcase
    return q;
  endfunction

  task automatic offer(input query_t q);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.point_x <= q.px;
    in_if.point_y <= q.py;
    in_if.rect_x1 <= q.x1;
    in_if.rect_y1 <= q.y1;
    in_if.rect_x2 <= q.x2;
    in_if.rect_y2 <= q.y2;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send(input coord_t px, input coord_t py, input coord_t x1,
                      input coord_t y1, input coord_t x2, input coord_t y2);
    query_t q;
    q = '{px: px, py: py, x1: x1, y1: y1, x2: x2, y2: y2};
    offer(q);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) offer(random_query());
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.point_x <= '0;
    in_if.point_y <= '0;
    in_if.rect_x1 <= '0;
    in_if.rect_y1 <= '0;
    in_if.rect_x2 <= '0;
    in_if.rect_y2 <= '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // directed
    send(0, 0, 0, 0, 0, 0);
    send(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX);
    send(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN);
    send(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN);
    send(0, 0, C_MIN, C_MIN, C_MAX, C_MAX);
    send(0, 0, C_MAX, C_MAX, C_MIN, C_MIN);
    send(5, 100, -10, -20, 30, 40);
    send(5, 100, 30, 40, -10, -20);
    send(-200, 7, -10, -20, 30, 40);
    send(-10, 7, -10, -20, 30, 40);
    send(30, 40, -10, -20, 30, 40);
    send(100, -300, -10, -20, 30, 40);
    send(3, 4, 10, -5, 10, 50);
    send(3, 4, -5, 10, 50, 10);
    send(3, 4, 0, 0, 0, 0);
    send(C_MAX, 0, C_MIN, -1, C_MIN, 1);
    send(-1, -1, 0, 0, 1, 1);
    send(1, 1, 0, 0, 2, 2);
    send(C_MIN, 0, C_MAX, C_MIN, C_MAX, C_MAX);

    send_random(600);

    // sender waits for every outstanding result
    in_if.valid <= 1'b0;
    drain();
    send_random(300);

    // result side holds off while queries keep coming: the pipe fills and stalls
    hold_req = 1'b1;
    send_random(200);

    idle_pct = 0;
    send_random(400);
    idle_pct = 10;
    send_random(430);

    in_if.valid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** point_rect_min_max_distance_core: PASSED **");
    end else begin
      $display("** point_rect_min_max_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
